// ===== sv/gtdc_pkg.sv =====
// Types, result codes and fixed widths for the tree clustering block.
// Used by the cell, the top level and the bench; depends on nothing.
`default_nettype none
package gtdc_pkg;

	localparam int DIST_W = 10;
	localparam int IDX_W  = 10;

	typedef enum logic [1:0] {
		ST_JOIN = 2'd0,
		ST_OPEN = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0]        bipart_hash;
		logic               hash_present;
		logic               last_of_tree;
		logic [23:0]        visits;
		logic signed [31:0] score;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         cluster_index;
		logic [7:0]         distance;
		logic [23:0]        member_total;
		logic [31:0]        visit_total;
		logic signed [31:0] best_score_out;
		logic signed [31:0] rep_score_out;
	} res_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic [63:0] hash;
		logic        cmp;
		logic        wr;
		logic        reduce;
		logic        clear;
		logic        commit;
		logic        attach;
	} cell_cmd_t;

	// Running first-minimum candidate handed along the cell row.
	typedef struct packed {
		logic               found;
		logic [DIST_W-1:0]  delta;
		logic [IDX_W-1:0]   idx;
		logic [23:0]        members;
		logic [31:0]        visits;
		logic signed [31:0] best;
		logic signed [31:0] rep;
	} cand_t;

endpackage
`default_nettype wire

// ===== sv/gtdc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// Stand-alone; no package needed.
`default_nettype none
module gtdc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/gtdc_cell.sv =====
// One cluster cell: representative hashes in a local RAM, a streaming merge
// counter, the cluster record, and one stage of the minimum chain.
// Depends on gtdc_pkg and gtdc_ram.
`default_nettype none
module gtdc_cell import gtdc_pkg::*; #(
	parameter int MAX_BIPARTS  = 64,
	parameter int MAX_CLUSTERS = 64,
	parameter int CELL_ID      = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cell_cmd_t                         cmd,
	input  wire logic [$clog2(MAX_BIPARTS)-1:0]    wr_addr,
	input  wire logic [$clog2(MAX_BIPARTS+1)-1:0]  tree_len,
	input  wire logic [$clog2(MAX_CLUSTERS+1)-1:0] open_cnt,
	input  wire logic [$clog2(MAX_CLUSTERS)-1:0]   target,
	input  wire logic [23:0]                       visits,
	input  wire logic signed [31:0]                score,
	input  wire cand_t                             cand_in,
	output cand_t                                  cand_q,
	output logic                                   pend_q
);
	localparam int AW = $clog2(MAX_BIPARTS);
	localparam int LW = $clog2(MAX_BIPARTS + 1);
	localparam int CW = $clog2(MAX_CLUSTERS + 1);
	localparam int IW = $clog2(MAX_CLUSTERS);
	localparam logic [CW-1:0] MY_CNT = CW'(CELL_ID);
	localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

	logic [LW-1:0] j_q, j_nxt, shared_q, sh_nxt, len_q;
	logic          pend_nxt, active, staging;
	logic [63:0]   rdata;
	logic [23:0]   members_q;
	logic [32:0]   vis_sum;
	logic [31:0]   visits_q;
	logic signed [31:0] best_q, rep_q;
	logic [LW:0]   span;
	cand_t         own;

	assign active  = MY_CNT < open_cnt;
	assign staging = MY_CNT == open_cnt;

	gtdc_ram #(.WIDTH(64), .DEPTH(MAX_BIPARTS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr && staging),
		.waddr (wr_addr),
		.wdata (cmd.hash),
		.raddr (j_nxt[AW-1:0]),
		.rdata (rdata)
	);

	// rdata always holds the representative hash at position j_q.
	always_comb begin
		j_nxt    = j_q;
		sh_nxt   = shared_q;
		pend_nxt = pend_q;
		if (cmd.clear) begin
			j_nxt    = '0;
			sh_nxt   = '0;
			pend_nxt = 1'b0;
		end else if (cmd.cmp) begin
			pend_nxt = active;
		end else if (pend_q) begin
			if (j_q >= len_q) begin
				pend_nxt = 1'b0;
			end else if (rdata < cmd.hash) begin
				j_nxt = j_q + LW'(1);
			end else if (rdata == cmd.hash) begin
				j_nxt    = j_q + LW'(1);
				sh_nxt   = shared_q + LW'(1);
				pend_nxt = 1'b0;
			end else begin
				pend_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q      <= '0;
			shared_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			j_q      <= j_nxt;
			shared_q <= sh_nxt;
			pend_q   <= pend_nxt;
		end
	end

	assign span = (LW+1)'(tree_len) + (LW+1)'(len_q) - {shared_q, 1'b0};
	assign vis_sum = {1'b0, visits_q} + 33'(visits);

	always_comb begin
		own.found   = 1'b1;
		own.delta   = DIST_W'(span);
		own.idx     = IDX_W'(CELL_ID);
		own.members = members_q;
		own.visits  = visits_q;
		own.best    = best_q;
		own.rep     = rep_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && staging) begin
			len_q     <= tree_len;
			members_q <= 24'd1;
			visits_q  <= 32'(visits);
			best_q    <= score;
			rep_q     <= score;
		end else if (cmd.attach && target == MY_IDX) begin
			if (members_q != '1) begin
				members_q <= members_q + 24'd1;
			end
			visits_q <= vis_sum[32] ? '1 : vis_sum[31:0];
			if (score < best_q) begin
				best_q <= score;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (cmd.reduce) begin
			if (active && (!cand_in.found || own.delta < cand_in.delta)) begin
				cand_q <= own;
			end else begin
				cand_q <= cand_in;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/greedy_tree_distance_clustering.sv =====
// Top level of the tree clustering block: sequencer, tree length and
// cluster count, threshold register and the row of cluster cells.
// Depends on gtdc_pkg and gtdc_cell.
//
// A tree arrives as a run of requests on start/req, one hash each, with
// last_of_tree set on the final one. A request is taken when start is high
// and busy is low. Each hash is broadcast to all open cluster cells, which
// step through their stored hashes in parallel, one per cycle; a request
// that stores a hash holds busy until every open cell has finished its
// merge step for it. After the last request the row hands the running
// minimum from cell to cell, then the decide state updates the cluster, and
// the result shows on res with done high for one cycle. A request that
// stores no hash and is not last leaves busy low. The receiver cannot
// stall; results are never held back. cfg_we writes the distance threshold
// and is meant for idle periods. Reset empties the cluster table, clears
// the threshold and the tree being collected.
`default_nettype none
module greedy_tree_distance_clustering import gtdc_pkg::*; #(
	parameter int MAX_BIPARTS  = 64,
	parameter int MAX_CLUSTERS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire req_t       req,
	output logic            done,
	output res_t            res,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	localparam int AW = $clog2(MAX_BIPARTS);
	localparam int LW = $clog2(MAX_BIPARTS + 1);
	localparam int CW = $clog2(MAX_CLUSTERS + 1);
	localparam int IW = $clog2(MAX_CLUSTERS);
	localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_BIPARTS);
	localparam logic [CW-1:0] OPEN_MAX = CW'(MAX_CLUSTERS);
	localparam logic [IW-1:0] CNT_LAST = IW'(MAX_CLUSTERS - 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MERGE  = 4'b0010,
		S_REDUCE = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [7:0]        thr_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     wr_ptr;
	logic [CW-1:0]     open_q;
	logic [IW-1:0]     cnt_q;
	logic              last_q, cmp_q, accept, take_hash;
	logic [63:0]       hash_q;
	logic [23:0]       visits_q;
	logic signed [31:0] score_q;
	cell_cmd_t         cmd;
	cand_t             chain [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] pend;
	cand_t             best;
	logic              hit, open_new;
	logic [32:0]       vis_sum;

	assign busy      = state_q != S_IDLE;
	assign accept    = start && !busy;
	assign take_hash = accept && req.hash_present && len_q < LEN_MAX;
	assign best      = chain[MAX_CLUSTERS-1];
	assign hit       = best.found && best.delta <= DIST_W'(thr_q);
	assign open_new  = !hit && open_q < OPEN_MAX;
	assign vis_sum   = {1'b0, best.visits} + 33'(visits_q);
	// The hash is stored in the cycle after acceptance, once it sits in hash_q.
	assign wr_ptr    = len_q - LW'(1);

	always_comb begin
		cmd.hash   = hash_q;
		cmd.cmp    = cmp_q;
		cmd.wr     = cmp_q;
		cmd.reduce = state_q == S_REDUCE;
		cmd.clear  = state_q == S_DECIDE;
		cmd.commit = state_q == S_DECIDE && open_new;
		cmd.attach = state_q == S_DECIDE && hit;
	end

	for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
		cand_t cin;
		if (k == 0) begin : g_head
			assign cin = '0;
		end else begin : g_link
			assign cin = chain[k-1];
		end
		gtdc_cell #(
			.MAX_BIPARTS  (MAX_BIPARTS),
			.MAX_CLUSTERS (MAX_CLUSTERS),
			.CELL_ID      (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.wr_addr  (wr_ptr[AW-1:0]),
			.tree_len (len_q),
			.open_cnt (open_q),
			.target   (best.idx[IW-1:0]),
			.visits   (visits_q),
			.score    (score_q),
			.cand_in  (cin),
			.cand_q   (chain[k]),
			.pend_q   (pend[k])
		);
	end

	always_ff @(posedge clk) begin
		if (take_hash) begin
			hash_q <= req.bipart_hash;
		end
		if (accept && req.last_of_tree) begin
			visits_q <= req.visits;
			score_q  <= req.score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q   <= '0;
			len_q   <= '0;
			open_q  <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			cmp_q   <= 1'b0;
			done    <= 1'b0;
		end else begin
			done  <= 1'b0;
			cmp_q <= take_hash;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						last_q <= req.last_of_tree;
						if (take_hash) begin
							len_q   <= len_q + LW'(1);
							state_q <= S_MERGE;
						end else if (req.last_of_tree) begin
							state_q <= S_REDUCE;
						end
					end
				end
				S_MERGE: begin
					// The compare request reaches the cells in the cycle after acceptance.
					if (!cmp_q && pend == '0) begin
						state_q <= last_q ? S_REDUCE : S_IDLE;
					end
				end
				S_REDUCE: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					len_q   <= '0;
					done    <= 1'b1;
					state_q <= S_IDLE;
					if (open_new) begin
						open_q <= open_q + CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			res.distance <= !best.found ? 8'd0 :
				(best.delta > DIST_W'(255) ? 8'd255 : best.delta[7:0]);
			if (hit) begin
				res.status         <= ST_JOIN;
				res.cluster_index  <= best.idx[5:0];
				res.member_total   <= (best.members == '1) ? best.members
				                                           : best.members + 24'd1;
				res.visit_total    <= vis_sum[32] ? '1 : vis_sum[31:0];
				res.best_score_out <= (score_q < best.best) ? score_q : best.best;
				res.rep_score_out  <= best.rep;
			end else if (open_new) begin
				res.status         <= ST_OPEN;
				res.cluster_index  <= 6'(open_q);
				res.member_total   <= 24'd1;
				res.visit_total    <= 32'(visits_q);
				res.best_score_out <= score_q;
				res.rep_score_out  <= score_q;
			end else begin
				res.status         <= ST_FULL;
				res.cluster_index  <= '0;
				res.member_total   <= '0;
				res.visit_total    <= '0;
				res.best_score_out <= '0;
				res.rep_score_out  <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== verif/greedy_tree_distance_clustering_tb.sv =====
// Self-checking bench for greedy_tree_distance_clustering: random trees built from a
// sorted hash pool, a transaction-level predictor of the cluster table and a result checker.
// Depends on gtdc_pkg and the greedy_tree_distance_clustering RTL.
`default_nettype none
module greedy_tree_distance_clustering_tb;
	import gtdc_pkg::*;

	localparam int NB = 64;
	localparam int NC = 64;
	localparam int POOL = 128;
	localparam int IDLE_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t res;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	greedy_tree_distance_clustering dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Predicted cluster table.
	logic [63:0] tree_hashes[NB];
	int unsigned tree_len;
	logic [63:0] rep_hash_mem[NC][NB];
	int unsigned rep_len[NC];
	logic [23:0] member_cnt[NC];
	logic [31:0] visit_sum[NC];
	logic signed [31:0] low_score[NC];
	logic signed [31:0] lead_score[NC];
	int unsigned open_count;
	logic [7:0] threshold;

	req_t pending_q[$];
	res_t cluster_result_q[$];
	logic [63:0] hash_pool[POOL];
	int gap_left;
	bit quiet;
	int errors;
	int idle_cycles;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("error: %s got %0h, want %0h", what, got, want);
		errors++;
	endtask

	function automatic int unsigned tree_gap(input int unsigned c);
		int unsigned i, j, shared;
		i = 0;
		j = 0;
		shared = 0;
		while (i < tree_len && j < rep_len[c]) begin
			if (tree_hashes[i] == rep_hash_mem[c][j]) begin
				shared++;
				i++;
				j++;
			end else if (tree_hashes[i] < rep_hash_mem[c][j]) i++;
			else j++;
		end
		return tree_len + rep_len[c] - 2 * shared;
	endfunction

	task automatic cluster_tree(input req_t r);
		int unsigned c, d_cur, best_d, best_c;
		bit found;
		res_t e;
		found = 0;
		best_d = 0;
		best_c = 0;
		e = '0;
		if (r.hash_present && tree_len < NB) begin
			tree_hashes[tree_len] = r.bipart_hash;
			tree_len++;
		end
		if (r.last_of_tree) begin
			for (c = 0; c < open_count; c++) begin
				d_cur = tree_gap(c);
				if (!found || d_cur < best_d) begin
					found = 1;
					best_d = d_cur;
					best_c = c;
					if (d_cur == 0) break;
				end
			end
			e.distance = (best_d > 255) ? 8'd255 : best_d[7:0];
			if (found && best_d <= threshold) begin
				c = best_c;
				if (member_cnt[c] != 24'hFFFFFF) member_cnt[c]++;
				if (visit_sum[c] > 32'hFFFFFFFF - {8'd0, r.visits}) visit_sum[c] = 32'hFFFFFFFF;
				else visit_sum[c] = visit_sum[c] + {8'd0, r.visits};
				if (r.score < low_score[c]) low_score[c] = r.score;
				e.status = ST_JOIN;
			end else if (open_count < NC) begin
				c = open_count;
				open_count++;
				for (int k = 0; k < tree_len; k++) rep_hash_mem[c][k] = tree_hashes[k];
				rep_len[c] = tree_len;
				member_cnt[c] = 24'd1;
				visit_sum[c] = {8'd0, r.visits};
				low_score[c] = r.score;
				lead_score[c] = r.score;
				e.status = ST_OPEN;
			end else begin
				e.status = ST_FULL;
			end
			if (e.status != ST_FULL) begin
				e.cluster_index = c[5:0];
				e.member_total = member_cnt[c];
				e.visit_total = visit_sum[c];
				e.best_score_out = low_score[c];
				e.rep_score_out = lead_score[c];
			end
			cluster_result_q.push_back(e);
			tree_len = 0;
		end
	endtask

	// Requests change on the falling edge.
	always @(negedge clk) begin
		if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (pending_q.size() != 0) begin
			start <= 1'b1;
			req <= pending_q[0];
		end else start <= 1'b0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (done) begin
				idle_cycles = 0;
				if (cluster_result_q.size() == 0)
					report("unexpected result", 64'(res.status), 64'd0);
				else begin
					want = cluster_result_q.pop_front();
					if (res.status != want.status)
						report("status", 64'(res.status), 64'(want.status));
					if (res.cluster_index != want.cluster_index)
						report("cluster_index", 64'(res.cluster_index),
							64'(want.cluster_index));
					if (res.distance != want.distance)
						report("distance", 64'(res.distance), 64'(want.distance));
					if (res.member_total != want.member_total)
						report("member_total", 64'(res.member_total),
							64'(want.member_total));
					if (res.visit_total != want.visit_total)
						report("visit_total", 64'(res.visit_total),
							64'(want.visit_total));
					if (res.best_score_out != want.best_score_out)
						report("best_score_out", 64'(res.best_score_out),
							64'(want.best_score_out));
					if (res.rep_score_out != want.rep_score_out)
						report("rep_score_out", 64'(res.rep_score_out),
							64'(want.rep_score_out));
				end
			end
			if (cfg_we) threshold = cfg_wdata;
			if (start && !busy) begin
				idle_cycles = 0;
				cluster_tree(req);
				void'(pending_q.pop_front());
				gap_left = quiet ? 0 : $urandom_range(0, 19);
			end else if (pending_q.size() != 0 || cluster_result_q.size() != 0) begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("greedy_tree_distance_clustering: mismatch");
					$finish;
				end
			end
		end
	end

	function automatic req_t make_item(input logic [63:0] h, input bit present, input bit last,
			input logic [23:0] v, input logic signed [31:0] s);
		req_t r;
		r.bipart_hash = h;
		r.hash_present = present;
		r.last_of_tree = last;
		r.visits = v;
		r.score = s;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [23:0] rand_visits();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic signed [31:0] rand_score();
		case ($urandom_range(0, 6))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			default: return $urandom();
		endcase
	endfunction

	// One tree from a mask over the sorted pool, so hashes come out ascending.
	task automatic queue_tree(input logic [POOL-1:0] mask, input logic [23:0] v,
			input logic signed [31:0] s);
		int last_i;
		last_i = -1;
		if ($urandom_range(0, 9) == 0)
			pending_q.push_back(make_item(rand64(), 1'b0, 1'b0, 24'($urandom()), $urandom()));
		for (int i = 0; i < POOL; i++) if (mask[i]) last_i = i;
		if (last_i < 0) pending_q.push_back(make_item(rand64(), 1'b0, 1'b1, v, s));
		for (int i = 0; i <= last_i; i++)
			if (mask[i]) pending_q.push_back(make_item(hash_pool[i], 1'b1, i == last_i, v, s));
	endtask

	function automatic logic [POOL-1:0] sparse_mask(input int density);
		logic [POOL-1:0] m;
		m = '0;
		for (int i = 0; i < POOL; i++) if ($urandom_range(0, 999) < density) m[i] = 1'b1;
		return m;
	endfunction

	task automatic write_threshold(input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && cluster_result_q.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		logic [63:0] tmp;
		logic [POOL-1:0] bases[6];
		logic [POOL-1:0] m;
		int j;
		errors = 0;
		idle_cycles = 0;
		gap_left = 0;
		quiet = 0;
		tree_len = 0;
		open_count = 0;
		threshold = '0;
		for (int i = 0; i < POOL; i++) hash_pool[i] = rand64();
		hash_pool[0] = 64'd1;
		hash_pool[POOL-1] = 64'hFFFFFFFFFFFFFFFF;
		for (int i = 1; i < POOL; i++) begin
			tmp = hash_pool[i];
			j = i - 1;
			while (j >= 0 && hash_pool[j] > tmp) begin
				hash_pool[j+1] = hash_pool[j];
				j--;
			end
			hash_pool[j+1] = tmp;
		end
		for (int i = 0; i < 6; i++) bases[i] = sparse_mask(40);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed trees: extremes, empty and overflowing trees, zero and unordered hashes.
		write_threshold(8'd0);
		pending_q.push_back(make_item(64'd0, 1'b1, 1'b1, 24'd0, 32'sh80000000));
		pending_q.push_back(make_item(64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1, 24'hFFFFFF,
			32'sh7FFFFFFF));
		pending_q.push_back(make_item(64'd5, 1'b0, 1'b1, 24'd7, -32'sd1));
		pending_q.push_back(make_item(64'd0, 1'b0, 1'b0, 24'd0, 32'sd0));
		pending_q.push_back(make_item(64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1, 24'd3, 32'sh80000000));
		pending_q.push_back(make_item(64'h9000, 1'b1, 1'b0, 24'd0, 32'sd0));
		pending_q.push_back(make_item(64'h10, 1'b1, 1'b0, 24'd0, 32'sd0));
		pending_q.push_back(make_item(64'h0, 1'b1, 1'b1, 24'd1, 32'sd5));
		queue_tree({POOL{1'b1}}, 24'hFFFFFF, 32'sh7FFFFFFF);
		queue_tree({POOL{1'b1}}, 24'h800000, 32'sh00010000);
		queue_tree(bases[0], 24'd1, 32'sd0);
		drain();

		write_threshold(8'd128);
		for (int t = 0; t < 20; t++) queue_tree(sparse_mask(35), rand_visits(), rand_score());
		drain();

		// Low thresholds on variants of a few base trees: opens, joins and a full table.
		quiet = 1;
		write_threshold(8'($urandom_range(1, 6)));
		for (int t = 0; t < 50; t++) begin
			m = bases[$urandom_range(0, 5)];
			repeat ($urandom_range(0, 4)) m[$urandom_range(0, POOL - 1)] ^= 1'b1;
			if ($urandom_range(0, 2) == 0) m = sparse_mask(30);
			queue_tree(m, rand_visits(), rand_score());
		end
		drain();
		quiet = 0;
		write_threshold(8'($urandom_range(2, 12)));
		for (int t = 0; t < 30; t++) begin
			m = bases[$urandom_range(0, 5)];
			repeat ($urandom_range(0, 6)) m[$urandom_range(0, POOL - 1)] ^= 1'b1;
			if ($urandom_range(0, 4) == 0) m = sparse_mask(30);
			queue_tree(m, rand_visits(), rand_score());
		end
		drain();

		// Everything joins: drives visit sums into saturation.
		write_threshold(8'd255);
		for (int t = 0; t < 280; t++) begin
			quiet = (t > 140 && t < 200);
			pending_q.push_back(make_item(rand64(), 1'b0, 1'b1, 24'hFFFFFF, rand_score()));
		end
		drain();
		quiet = 0;

		write_threshold(8'd0);
		for (int t = 0; t < 40; t++) queue_tree(sparse_mask(40), rand_visits(), rand_score());
		drain();

		if (errors == 0) $display("greedy_tree_distance_clustering: match");
		else $display("greedy_tree_distance_clustering: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/gtdc_pkg.sv
sv/gtdc_ram.sv
sv/gtdc_cell.sv
sv/greedy_tree_distance_clustering.sv
verif/greedy_tree_distance_clustering_tb.sv
